>>> design/rate_limit_delay_shaper_defines.svh
// Assertion macros for the rate limit delay shaper.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef RATE_LIMIT_DELAY_SHAPER_DEFINES_SVH
`define RATE_LIMIT_DELAY_SHAPER_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked every cycle outside reset.
`define RLDS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rlds check failed");
// Antecedent in this cycle implies consequent in the next.
`define RLDS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rlds sequence check failed");
`else
`define RLDS_ASSERT(lbl, prop)
`define RLDS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/rlds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rlds_pkg;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_BANDWIDTH = 3'd0;
   localparam logic [2:0] CSR_DELAY     = 3'd1;
   localparam logic [2:0] CSR_SLOTS     = 3'd2;
   localparam logic [2:0] CSR_BYTES     = 3'd3;
   localparam logic [2:0] CSR_LOSS      = 3'd4;

   // Request and event codes
   localparam logic       REQ_ARRIVAL   = 1'b0;
   localparam logic [1:0] EV_ACCEPT     = 2'd0;
   localparam logic [1:0] EV_DROP       = 2'd1;
   localparam logic [1:0] EV_DELIVER    = 2'd2;
   localparam logic [1:0] DIR_DISCARD   = 2'd3;

   localparam logic [5:0]  RESULT_CAP   = 6'd33;
   localparam logic [32:0] CREDIT_MAX   = 33'h1_FFFF_FFFF;
   localparam logic [20:0] BYTES_MAX    = 21'h1F_FFFF;

   typedef struct packed {
      logic        req_type;
      logic [15:0] packet_length;
      logic [7:0]  packet_tag;
      logic [1:0]  direction;
      logic [30:0] random_value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [7:0]  out_tag;
      logic [15:0] out_length;
      logic [1:0]  out_direction;
      logic [31:0] drop_total;
      logic        last;
   } rsp_item_type;

   // Per-slot packet descriptor
   typedef struct packed {
      logic [15:0] length;
      logic [7:0]  tag;
      logic [1:0]  direction;
   } slot_type;

endpackage
`default_nettype wire

>>> design/rate_limit_delay_shaper.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rate_limit_delay_shaper_defines.svh"
// Token bucket shaper followed by a delay line, for one emulated link.
// Requests: pulse start with req_data while busy is low. An arrival gives one
// accepted or dropped event, and when it lands in an empty rate queue it may
// also be delivered at once. A tick adds credit and releases packets.
// Results: rsp_strobe marks each event for exactly one cycle; last flags the
// final event of a request. The receiver cannot stall, so no backpressure.
// Configuration: csr_valid/csr_ready write register csr_index while idle.
// An arrival that is dropped or queued behind others goes straight to the close.
// A queue walk makes a read step and an update step for each packet moved from
// the rate queue to the delay queue and each packet delivered, as the slot
// memories have a registered read that must precede each update.
// Each result is held until the next one is found or the walk closes, then
// leaves through an output register; the final one is strobed in the cycle
// after the closing cycle. Items are processed one at a time.
// Reset: all queues empty, credit and drop count zero, registers at their
// defaults (no rate limit, no delay, 32 slots, no byte limit, no loss).
module rate_limit_delay_shaper #(
   parameter int QUEUE_SLOTS      = 32,
   parameter int TICKS_PER_SECOND = 100
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire rlds_pkg::req_item_type req_data,
   output logic                    rsp_strobe,
   output rlds_pkg::rsp_item_type  rsp_data,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire [2:0]               csr_index,
   input  wire [30:0]              csr_data
);
   import rlds_pkg::*;

   localparam int PW = $clog2(QUEUE_SLOTS);
   localparam int CW = $clog2(QUEUE_SLOTS + 1);
   localparam int MW = $clog2(8 * TICKS_PER_SECOND + 1);
   localparam logic [MW-1:0] NEED_MUL = MW'(8 * TICKS_PER_SECOND);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_RATE_RD  = 6'b000010,
      ST_RATE_CHK = 6'b000100,
      ST_DLY_RD   = 6'b001000,
      ST_DLY_CHK  = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [30:0] bw_ff, loss_ff;
   logic [15:0] dt_ff;
   logic [5:0]  slot_lim_ff;
   logic [20:0] byte_lim_ff;

   // Queue state
   logic [PW-1:0] dh_ff, dh_in, rh_ff, rh_in, tail_ff, tail_in;
   logic [CW-1:0] rc_ff, rc_in, dc_ff, dc_in;
   logic [20:0]   rb_ff, rb_in;
   logic [32:0]   credit_ff, credit_in;
   logic [15:0]   tsi_ff, tsi_in;
   logic [31:0]   drops_ff, drops_in;
   logic          imm_ff, imm_in, dec_ff, dec_in;
   logic [5:0]    n_ff, n_in;

   // Pending result and output register
   logic          pend_valid_ff, pend_valid_in;
   rsp_item_type  pend_ff, pend_in;
   logic          strobe_ff, strobe_in;
   rsp_item_type  rsp_ff, rsp_in;

   // Slot memories
   slot_type      pay_mem [QUEUE_SLOTS];
   logic [16:0]   dly_mem [QUEUE_SLOTS];
   slot_type      pay_rd_ff;
   logic [16:0]   dly_rd_ff;
   logic [PW-1:0] rd_addr;
   logic          pay_we, dly_we;
   logic [PW-1:0] dly_waddr;
   logic [16:0]   dly_wdata;

   // Helper values
   logic [15+MW:0] need_prod;
   logic [32:0]    need;
   logic [33:0]    credit_sum;
   logic [21:0]    bytes_sum;
   logic           drop;
   logic [16:0]    dly_eff;
   logic [16:0]    d_rel;
   rsp_item_type   new_rsp;

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
      next_slot = (p == PW'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
   endfunction

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = ~busy;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;
   assign rd_addr    = (state_ff == ST_RATE_RD) ? rh_ff : dh_ff;

   // Credit needed by the packet at the rate head
   assign need_prod  = pay_rd_ff.length * NEED_MUL;
   assign need       = 33'(need_prod);
   assign credit_sum = {1'b0, credit_ff} + 34'(bw_ff);
   assign bytes_sum  = 22'(req_data.packet_length) + 22'(rb_ff);

   // Admission check for an arrival
   assign drop = (loss_ff != '0 && req_data.random_value < loss_ff) ||
                 (slot_lim_ff != '0 && 7'(rc_ff) >= 7'(slot_lim_ff)) ||
                 (byte_lim_ff != '0 && bytes_sum > 22'(byte_lim_ff)) ||
                 (7'(rc_ff) + 7'(dc_ff) >= 7'(QUEUE_SLOTS));

   // Delay seen at the head after this tick's decrement
   assign dly_eff = (dec_ff && dly_rd_ff != '0) ? dly_rd_ff - 1'b1 : dly_rd_ff;
   // Delay stamped on a packet leaving the rate queue
   assign d_rel = (!imm_ff && tsi_ff != '0 && dc_ff == '0) ?
                  17'(tsi_ff) + 17'd1 : 17'(tsi_ff);

   // Control and datapath
   always_comb begin
      state_in      = state_ff;
      dh_in         = dh_ff;
      rh_in         = rh_ff;
      tail_in       = tail_ff;
      rc_in         = rc_ff;
      dc_in         = dc_ff;
      rb_in         = rb_ff;
      credit_in     = credit_ff;
      tsi_in        = tsi_ff;
      drops_in      = drops_ff;
      imm_in        = imm_ff;
      dec_in        = dec_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      strobe_in     = 1'b0;
      rsp_in        = rsp_ff;
      pay_we        = 1'b0;
      dly_we        = 1'b0;
      dly_waddr     = tail_ff;
      dly_wdata     = '0;
      new_rsp       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid && csr_index == CSR_DELAY) begin
               tsi_in = csr_data[15:0];
            end
            if (start) begin
               n_in = '0;
               if (req_data.req_type != REQ_ARRIVAL) begin
                  // Tick: refill credit unless the rate queue is empty and credit already holds a tick's bandwidth
                  if (rc_ff != '0 || credit_ff < 33'(bw_ff)) begin
                     credit_in = (credit_sum > 34'(CREDIT_MAX)) ? CREDIT_MAX :
                                 credit_sum[32:0];
                  end
                  tsi_in = (dc_ff == '0) ? dt_ff :
                           ((tsi_ff < dt_ff) ? tsi_ff + 1'b1 : tsi_ff);
                  imm_in = 1'b0;
                  dec_in = 1'b1;
                  if (rc_ff != '0)      state_in = ST_RATE_RD;
                  else if (dc_ff != '0) state_in = ST_DLY_RD;
                  else                  state_in = ST_DONE;
               end else if (drop) begin
                  drops_in      = drops_ff + 1'b1;
                  pend_valid_in = 1'b1;
                  pend_in       = '{EV_DROP, req_data.packet_tag,
                                    req_data.packet_length, req_data.direction,
                                    drops_ff + 1'b1, 1'b0};
                  state_in      = ST_DONE;
               end else begin
                  pay_we        = 1'b1;
                  dly_we        = 1'b1;
                  tail_in       = next_slot(tail_ff);
                  rc_in         = rc_ff + 1'b1;
                  rb_in         = bytes_sum > 22'(BYTES_MAX) ? BYTES_MAX :
                                  bytes_sum[20:0];
                  pend_valid_in = 1'b1;
                  pend_in       = '{EV_ACCEPT, req_data.packet_tag,
                                    req_data.packet_length, req_data.direction,
                                    drops_ff, 1'b0};
                  n_in          = 6'd1;
                  if (rc_ff == '0) begin
                     // Empty rate queue: move at once, no tick adjustments
                     tsi_in   = (dc_ff == '0) ? dt_ff : tsi_ff;
                     imm_in   = 1'b1;
                     dec_in   = 1'b0;
                     state_in = ST_RATE_RD;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end

         ST_RATE_RD: state_in = ST_RATE_CHK;

         // Release the rate head if credit covers it
         ST_RATE_CHK: begin
            if (bw_ff == '0 || credit_ff >= need) begin
               if (bw_ff != '0) credit_in = credit_ff - need;
               rc_in     = rc_ff - 1'b1;
               rb_in     = (rb_ff >= 21'(pay_rd_ff.length)) ?
                           rb_ff - 21'(pay_rd_ff.length) : '0;
               tsi_in    = '0;
               dly_we    = 1'b1;
               dly_waddr = rh_ff;
               dly_wdata = d_rel;
               dc_in     = dc_ff + 1'b1;
               rh_in     = next_slot(rh_ff);
               state_in  = (rc_ff > CW'(1)) ? ST_RATE_RD : ST_DLY_RD;
            end else begin
               state_in  = (dc_ff != '0) ? ST_DLY_RD : ST_DONE;
            end
         end

         ST_DLY_RD: state_in = ST_DLY_CHK;

         // Decrement the head once per tick, deliver expired heads
         ST_DLY_CHK: begin
            dec_in = 1'b0;
            if (dec_ff && dly_rd_ff != '0) begin
               dly_we    = 1'b1;
               dly_waddr = dh_ff;
               dly_wdata = dly_eff;
            end
            if (dly_eff == '0 && n_ff < RESULT_CAP) begin
               dh_in = next_slot(dh_ff);
               dc_in = dc_ff - 1'b1;
               if (pay_rd_ff.direction != DIR_DISCARD) begin
                  new_rsp = '{EV_DELIVER, pay_rd_ff.tag, pay_rd_ff.length,
                              pay_rd_ff.direction, drops_ff, 1'b0};
                  n_in    = n_ff + 1'b1;
                  if (pend_valid_ff) begin
                     strobe_in = 1'b1;
                     rsp_in    = pend_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = new_rsp;
               end
               state_in = (dc_ff > CW'(1)) ? ST_DLY_RD : ST_DONE;
            end else begin
               state_in = ST_DONE;
            end
         end

         // Flush the final result with last set
         ST_DONE: begin
            if (pend_valid_ff) begin
               strobe_in   = 1'b1;
               rsp_in      = pend_ff;
               rsp_in.last = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dh_ff         <= '0;
         rh_ff         <= '0;
         tail_ff       <= '0;
         rc_ff         <= '0;
         dc_ff         <= '0;
         rb_ff         <= '0;
         credit_ff     <= '0;
         tsi_ff        <= '0;
         drops_ff      <= '0;
         imm_ff        <= 1'b0;
         dec_ff        <= 1'b0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dh_ff         <= dh_in;
         rh_ff         <= rh_in;
         tail_ff       <= tail_in;
         rc_ff         <= rc_in;
         dc_ff         <= dc_in;
         rb_ff         <= rb_in;
         credit_ff     <= credit_in;
         tsi_ff        <= tsi_in;
         drops_ff      <= drops_in;
         imm_ff        <= imm_in;
         dec_ff        <= dec_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff       <= '0;
         dt_ff       <= '0;
         slot_lim_ff <= 6'd32;
         byte_lim_ff <= '0;
         loss_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BANDWIDTH: bw_ff       <= csr_data;
            CSR_DELAY:     dt_ff       <= csr_data[15:0];
            CSR_SLOTS:     slot_lim_ff <= csr_data[5:0];
            CSR_BYTES:     byte_lim_ff <= csr_data[20:0];
            CSR_LOSS:      loss_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Slot memories: one write port each, registered read
   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[tail_ff] <= '{req_data.packet_length, req_data.packet_tag,
                               req_data.direction};
      end
      if (dly_we) begin
         dly_mem[dly_waddr] <= dly_wdata;
      end
      pay_rd_ff <= pay_mem[rd_addr];
      dly_rd_ff <= dly_mem[rd_addr];
   end

   // Checks
   `RLDS_ASSERT(a_ring_bound, (7'(rc_ff) + 7'(dc_ff) <= 7'(QUEUE_SLOTS)))
   `RLDS_ASSERT(a_no_pend_idle, !(state_ff == ST_IDLE && pend_valid_ff))
   `RLDS_ASSERT_NEXT(a_start_busy, start && !busy, busy)
   `RLDS_ASSERT_NEXT(a_strobe_src, strobe_in, rsp_strobe && $past(busy))

endmodule
`default_nettype wire
